// ===== hdl/pitpc_pkg.sv =====
// Shared types, constants and the control program of the PI temperature/PWM core.
// No dependencies; imported by pitpc_seq and pi_temperature_pwm_controller_core.
`default_nettype none

package pitpc_pkg;

  // Default values of the top-level parameters
  localparam int unsigned ADC_BITS_DEF       = 12;
  localparam int unsigned GAIN_FRAC_BITS_DEF = 12;
  localparam int unsigned ACC_WIDTH_DEF      = 40;

  // Register widths and reset values
  localparam int unsigned REG_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [REG_W-1:0] SETPOINT_RST     = 16'd10240;
  localparam logic [REG_W-1:0] SAMPLE_GAIN_RST  = 16'd1200;
  localparam logic [REG_W-1:0] PROP_GAIN_RST    = 16'd10957;
  localparam logic [REG_W-1:0] INTEG_GAIN_RST   = 16'd112;
  localparam logic [REG_W-1:0] OUTPUT_SCALE_RST = 16'd950;
  localparam logic [REG_W-1:0] PWM_PERIOD_RST   = 16'd48828;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT     = 3'd0,
    REG_SAMPLE_GAIN  = 3'd1,
    REG_PROP_GAIN    = 3'd2,
    REG_INTEG_GAIN   = 3'd3,
    REG_OUTPUT_SCALE = 3'd4,
    REG_PWM_PERIOD   = 3'd5
  } reg_idx_e;

  // Shared multiplier: signed 25 x 18
  localparam int unsigned MUL_A_W = 25;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Error / delta widths, accumulator split point for the duty product
  localparam int unsigned ERR_W  = 17;
  localparam int unsigned WORK_W = 37;
  localparam int unsigned LO_W   = 24;

  localparam logic [23:0]  TEMP_MAX = 24'd32767;
  localparam logic [16:0]  DUTY_ONE = 17'h10000;

  // Sequencer
  localparam int unsigned PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,   // latch input sample
    OP_TEMP,     // temperature and error from product
    OP_LOAD_P1,  // work = e*(kp+ki)
    OP_SUB_P2,   // work -= e_prev*kp
    OP_ACC,      // saturating accumulate, shift error history
    OP_DLO,      // duty product, low half
    OP_DHI,      // duty product, high half added
    OP_DUTY,     // shift and clamp duty
    OP_OUT       // load output register
  } op_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_TEMP,    // code * sample_gain
    MUL_P1,      // err * (kp + ki)
    MUL_P2,      // last_err * kp
    MUL_LO,      // acc[lo] * output_scale
    MUL_HI,      // acc[hi] * output_scale
    MUL_CMP      // period * duty
  } mul_sel_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,   // hold until an input request arrives
    JMP_IF_NEG,    // to target when the accumulator is negative
    JMP_WAIT_OUT   // hold while output register is full, then to target
  } jmp_e;

  typedef struct packed {
    op_e      op;
    mul_sel_e mul;
    jmp_e     jmp;
    pc_t      target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic acc_neg;
    logic out_busy;
  } stat_t;

  localparam pc_t STEP_IDLE = 4'd0;
  localparam pc_t STEP_OUT  = 4'd12;

  function automatic ctrl_t ucode_word(input pc_t pc);
    ctrl_t w;
    w = '{op: OP_NOP, mul: MUL_NONE, jmp: JMP_NEXT, target: STEP_IDLE};
    case (pc)
      4'd0:  w = '{op: OP_ACCEPT, mul: MUL_NONE, jmp: JMP_WAIT_IN,  target: STEP_IDLE};
      4'd1:  w = '{op: OP_NOP,    mul: MUL_TEMP, jmp: JMP_NEXT,     target: STEP_IDLE};
      4'd2:  w = '{op: OP_TEMP,   mul: MUL_NONE, jmp: JMP_NEXT,     target: STEP_IDLE};
      4'd3:  w = '{op: OP_NOP,    mul: MUL_P1,   jmp: JMP_NEXT,     target: STEP_IDLE};
      4'd4:  w = '{op: OP_LOAD_P1, mul: MUL_P2,  jmp: JMP_NEXT,     target: STEP_IDLE};
      4'd5:  w = '{op: OP_SUB_P2, mul: MUL_NONE, jmp: JMP_NEXT,     target: STEP_IDLE};
      4'd6:  w = '{op: OP_ACC,    mul: MUL_NONE, jmp: JMP_NEXT,     target: STEP_IDLE};
      4'd7:  w = '{op: OP_NOP,    mul: MUL_LO,   jmp: JMP_IF_NEG,   target: STEP_OUT};
      4'd8:  w = '{op: OP_DLO,    mul: MUL_HI,   jmp: JMP_NEXT,     target: STEP_IDLE};
      4'd9:  w = '{op: OP_DHI,    mul: MUL_NONE, jmp: JMP_NEXT,     target: STEP_IDLE};
      4'd10: w = '{op: OP_DUTY,   mul: MUL_NONE, jmp: JMP_NEXT,     target: STEP_IDLE};
      4'd11: w = '{op: OP_NOP,    mul: MUL_CMP,  jmp: JMP_NEXT,     target: STEP_IDLE};
      4'd12: w = '{op: OP_OUT,    mul: MUL_NONE, jmp: JMP_WAIT_OUT, target: STEP_IDLE};
      // unused steps fall back to idle
      default: w = '{op: OP_NOP,  mul: MUL_NONE, jmp: JMP_WAIT_OUT, target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pitpc_seq.sv =====
// Step counter and control-store lookup for the PI temperature/PWM core.
// Depends on pitpc_pkg (control word format and program).
`default_nettype none

module pitpc_seq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  pitpc_pkg::stat_t     stat_i,
  output pitpc_pkg::ctrl_t     ctrl_o
);
  import pitpc_pkg::*;

  pc_t   pc_q, pc_d;
  ctrl_t ctrl;

  always_comb begin
    ctrl = ucode_word(pc_q);
  end

  always_comb begin
    pc_d = pc_q + 1'b1;
    unique case (ctrl.jmp)
      JMP_NEXT:     pc_d = pc_q + 1'b1;
      JMP_WAIT_IN:  pc_d = stat_i.in_valid ? pc_q + 1'b1 : pc_q;
      JMP_IF_NEG:   pc_d = stat_i.acc_neg ? ctrl.target : pc_q + 1'b1;
      JMP_WAIT_OUT: pc_d = stat_i.out_busy ? pc_q : ctrl.target;
      default:      pc_d = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

`default_nettype wire

// ===== hdl/pi_temperature_pwm_controller_core.sv =====
// Top level of the PI temperature/PWM core: config registers, datapath, I/O regs.
// Depends on pitpc_pkg and pitpc_seq.
//
// Usage:
//   s_axis carries one ADC sample per request; m_axis returns one result per
//   sample: PWM compare value, measured temperature (tdata) and a clamp flag
//   (tuser). Gains, setpoint and period are written through cfg_we_i /
//   cfg_addr_i / cfg_data_i while no sample is in flight.
//   A microprogram of 13 steps drives one shared 25x18 multiplier; up to six
//   products are made per sample (four when the accumulator is negative and the
//   duty path is skipped). The next request is taken the cycle after the result
//   is loaded, so a new sample is not accepted before the last one is through;
//   the products go through the single multiplier one step at a time, between
//   the steps that use them.
//   The result waits in an output register; if the receiver stalls, the
//   program holds at its final step until that register drains.
//   Reset clears the accumulator and error history, loads the register
//   defaults, and leaves the output channel empty.
`default_nettype none

module pi_temperature_pwm_controller_core #(
  parameter int unsigned ADC_BITS       = pitpc_pkg::ADC_BITS_DEF,
  parameter int unsigned GAIN_FRAC_BITS = pitpc_pkg::GAIN_FRAC_BITS_DEF,
  parameter int unsigned ACC_WIDTH      = pitpc_pkg::ACC_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // config write port
  input  wire logic                              cfg_we_i,
  input  wire logic [pitpc_pkg::CFG_IDX_W-1:0]   cfg_addr_i,
  input  wire logic [pitpc_pkg::REG_W-1:0]       cfg_data_i,
  // sample stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [((ADC_BITS+7)/8)*8-1:0]     s_axis_tdata,  // adc_code
  // result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [31:0]                            m_axis_tdata,  // compare_value, measured_temp
  output logic                                   m_axis_tuser   // saturated
);
  import pitpc_pkg::*;

  localparam int unsigned MAG_W   = ACC_WIDTH - 1;
  localparam int unsigned HI_W    = MAG_W - LO_W;
  localparam int unsigned DFULL_W = MAG_W + REG_W;
  localparam int unsigned SHIFT   = GAIN_FRAC_BITS + 8;
  localparam int unsigned SUM_W   = ((ACC_WIDTH > WORK_W) ? ACC_WIDTH : WORK_W) + 1;

  // ---------------- configuration registers ----------------
  logic [REG_W-1:0] setpoint_q, sample_gain_q, prop_gain_q, integ_gain_q;
  logic [REG_W-1:0] output_scale_q, pwm_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q     <= SETPOINT_RST;
      sample_gain_q  <= SAMPLE_GAIN_RST;
      prop_gain_q    <= PROP_GAIN_RST;
      integ_gain_q   <= INTEG_GAIN_RST;
      output_scale_q <= OUTPUT_SCALE_RST;
      pwm_period_q   <= PWM_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_SETPOINT:     setpoint_q     <= cfg_data_i;
        REG_SAMPLE_GAIN:  sample_gain_q  <= cfg_data_i;
        REG_PROP_GAIN:    prop_gain_q    <= cfg_data_i;
        REG_INTEG_GAIN:   integ_gain_q   <= cfg_data_i;
        REG_OUTPUT_SCALE: output_scale_q <= cfg_data_i;
        REG_PWM_PERIOD:   pwm_period_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  ctrl_t ctrl;
  stat_t stat;

  logic                       out_valid_q;
  logic                       out_busy;
  logic signed [ACC_WIDTH-1:0] acc_q;

  assign out_busy = out_valid_q && !m_axis_tready;

  always_comb begin
    stat.in_valid = s_axis_tvalid;
    stat.acc_neg  = acc_q[ACC_WIDTH-1];
    stat.out_busy = out_busy;
  end

  pitpc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign s_axis_tready = (ctrl.op == OP_ACCEPT);

  // ---------------- shared multiplier ----------------
  logic [ADC_BITS-1:0]        code_q;
  logic signed [ERR_W-1:0]    err_q, last_err_q;
  logic [16:0]                duty_q;
  logic [ERR_W-1:0]           kpi;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  prod_q;

  assign kpi = {1'b0, prop_gain_q} + {1'b0, integ_gain_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.mul)
      MUL_TEMP: begin
        mul_a = $signed({{(MUL_A_W-ADC_BITS){1'b0}}, code_q});
        mul_b = $signed({{(MUL_B_W-REG_W){1'b0}}, sample_gain_q});
      end
      MUL_P1: begin
        mul_a = $signed({{(MUL_A_W-ERR_W){err_q[ERR_W-1]}}, err_q});
        mul_b = $signed({{(MUL_B_W-ERR_W){1'b0}}, kpi});
      end
      MUL_P2: begin
        mul_a = $signed({{(MUL_A_W-ERR_W){last_err_q[ERR_W-1]}}, last_err_q});
        mul_b = $signed({{(MUL_B_W-REG_W){1'b0}}, prop_gain_q});
      end
      MUL_LO: begin
        mul_a = $signed({{(MUL_A_W-LO_W){1'b0}}, acc_q[LO_W-1:0]});
        mul_b = $signed({{(MUL_B_W-REG_W){1'b0}}, output_scale_q});
      end
      MUL_HI: begin
        mul_a = $signed({{(MUL_A_W-HI_W){1'b0}}, acc_q[MAG_W-1:LO_W]});
        mul_b = $signed({{(MUL_B_W-REG_W){1'b0}}, output_scale_q});
      end
      MUL_CMP: begin
        mul_a = $signed({{(MUL_A_W-REG_W){1'b0}}, pwm_period_q});
        mul_b = $signed({{(MUL_B_W-17){1'b0}}, duty_q});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.mul != MUL_NONE) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // ---------------- datapath ----------------
  logic [23:0]                 traw;
  logic [REG_W-1:0]            temp_d, temp_q;
  logic signed [ERR_W-1:0]     err_d;
  logic signed [WORK_W-1:0]    work_q;
  logic signed [SUM_W-1:0]     sum;
  logic signed [ACC_WIDTH-1:0] acc_sat;
  logic [DFULL_W-1:0]          dfull_q;
  logic [DFULL_W-1:0]          dshift;
  logic                        duty_hi_q;
  logic [REG_W-1:0]            cmp_d;
  logic                        sat_d;
  logic [REG_W-1:0]            out_cmp_q, out_temp_q;
  logic                        out_sat_q;

  // temperature saturates high; error is exact in 17 bits
  assign traw   = prod_q[31:8];
  assign temp_d = (traw > TEMP_MAX) ? TEMP_MAX[REG_W-1:0] : traw[REG_W-1:0];
  assign err_d  = $signed({setpoint_q[REG_W-1], setpoint_q}) - $signed({1'b0, temp_d});

  assign sum = $signed({{(SUM_W-ACC_WIDTH){acc_q[ACC_WIDTH-1]}}, acc_q})
             + $signed({{(SUM_W-WORK_W){work_q[WORK_W-1]}}, work_q});

  // overflow when the bits above the accumulator width disagree with its sign
  always_comb begin
    acc_sat = sum[ACC_WIDTH-1:0];
    if (sum[SUM_W-1] && !(&sum[SUM_W-1:ACC_WIDTH-1])) begin
      acc_sat = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    end else if (!sum[SUM_W-1] && (|sum[SUM_W-1:ACC_WIDTH-1])) begin
      acc_sat = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end
  end

  assign dshift = dfull_q >> SHIFT;

  always_comb begin
    if (acc_q[ACC_WIDTH-1]) begin
      cmp_d = '0;
      sat_d = 1'b1;
    end else if (duty_hi_q) begin
      cmp_d = pwm_period_q;
      sat_d = 1'b1;
    end else begin
      cmp_d = prod_q[31:16];
      sat_d = 1'b0;
    end
  end

  // state with defined reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      last_err_q <= '0;
    end else if (ctrl.op == OP_ACC) begin
      acc_q      <= acc_sat;
      last_err_q <= err_q;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (ctrl.op)
      OP_ACCEPT: begin
        if (s_axis_tvalid) begin
          code_q <= s_axis_tdata[ADC_BITS-1:0];
        end
      end
      OP_TEMP: begin
        temp_q <= temp_d;
        err_q  <= err_d;
      end
      OP_LOAD_P1: work_q <= prod_q[WORK_W-1:0];
      OP_SUB_P2:  work_q <= work_q - prod_q[WORK_W-1:0];
      OP_DLO:     dfull_q <= {{(DFULL_W-LO_W-REG_W){1'b0}}, prod_q[LO_W+REG_W-1:0]};
      OP_DHI:     dfull_q <= dfull_q + {prod_q[HI_W+REG_W-1:0], {LO_W{1'b0}}};
      OP_DUTY: begin
        duty_hi_q <= (dshift > {{(DFULL_W-17){1'b0}}, DUTY_ONE});
        duty_q    <= dshift[16:0];
      end
      OP_OUT: begin
        if (!out_busy) begin
          out_cmp_q  <= cmp_d;
          out_temp_q <= temp_q;
          out_sat_q  <= sat_d;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.op == OP_OUT && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_temp_q, out_cmp_q};
  assign m_axis_tuser  = out_sat_q;

endmodule

`default_nettype wire
